// File: rtl/core/kepler_equation_solver_assert.svh
// assertion macros for the kepler equation solver
`ifndef KEPLER_EQUATION_SOLVER_ASSERT_SVH
`define KEPLER_EQUATION_SOLVER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, clocked on i_clk, off during reset
`define KES_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kes check failed");
// next-cycle implication
`define KES_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kes next-cycle check failed");
`else
`define KES_CHECK(lbl, ante, cons)
`define KES_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/kes_pkg.sv
package kes_pkg;

    // field widths
    localparam int ANGLE_W = 32;
    localparam int ITER_OUT_W = 5;
    localparam int REG_W = 16;

    // cordic and scaling constants
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [27:0] INV_TWO_PI = 28'd170891319;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // register indexes
    localparam logic REG_ECC = 1'b0;
    localparam logic REG_TOL = 1'b1;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] atan_at(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/kes_if.sv
// mean anomaly channel
interface kes_in_if;
    logic valid;
    logic ready;
    logic [kes_pkg::ANGLE_W-1:0] mean_anomaly;

    modport source (output valid, output mean_anomaly, input ready);
    modport sink (input valid, input mean_anomaly, output ready);
endinterface

// true anomaly channel
interface kes_out_if;
    logic valid;
    logic ready;
    logic [kes_pkg::ANGLE_W-1:0] true_anomaly;
    logic [kes_pkg::ITER_OUT_W-1:0] iterations_used;
    logic not_converged;

    modport source (output valid, output true_anomaly, output iterations_used,
                    output not_converged, input ready);
    modport sink (input valid, input true_anomaly, input iterations_used,
                  input not_converged, output ready);
endinterface

// File: rtl/core/kepler_equation_solver.sv
// each newton iteration runs 31 cordic steps, a 62-step divider and the map, multiply
// and update states; then come a half-angle rotation, sqrt, atan2 and output,
// or output at once when the eccentric anomaly lands on pi
// one transaction at a time, set by the shared cordic and divider
// reset: synchronous active-low i_rst_n, eccentricity 0, tolerance 16, block idle
`include "kepler_equation_solver_assert.svh"

module kepler_equation_solver #(
    parameter int MAX_ITER = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kes_in_if.sink               i_req,
    kes_out_if.source            o_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int ITER_W = $clog2(MAX_ITER + 1);

    typedef enum logic [16:0] {
        S_IDLE  = 17'b0_0000_0000_0000_0001,
        S_ROT   = 17'b0_0000_0000_0000_0010,
        S_MAP   = 17'b0_0000_0000_0000_0100,
        S_MSIN  = 17'b0_0000_0000_0000_1000,
        S_MTERM = 17'b0_0000_0000_0001_0000,
        S_MCOS  = 17'b0_0000_0000_0010_0000,
        S_DEN   = 17'b0_0000_0000_0100_0000,
        S_DIV   = 17'b0_0000_0000_1000_0000,
        S_UPD   = 17'b0_0000_0001_0000_0000,
        S_CHK   = 17'b0_0000_0010_0000_0000,
        S_SQ1   = 17'b0_0000_0100_0000_0000,
        S_SQ2   = 17'b0_0000_1000_0000_0000,
        S_MX    = 17'b0_0001_0000_0000_0000,
        S_MY    = 17'b0_0010_0000_0000_0000,
        S_VLD   = 17'b0_0100_0000_0000_0000,
        S_VEC   = 17'b0_1000_0000_0000_0000,
        S_OUT   = 17'b1_0000_0000_0000_0000
    } t_state;

    // registers
    t_state r_state, n_state;
    logic [15:0] r_ecc, n_ecc;
    logic [15:0] r_tol, n_tol;
    logic [31:0] r_m, n_m;
    logic [31:0] r_e, n_e;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic r_done, n_done;
    logic r_final, n_final;
    logic [5:0] r_cnt, n_cnt;
    logic signed [35:0] r_cx, n_cx;
    logic signed [35:0] r_cy, n_cy;
    logic signed [33:0] r_cz, n_cz;
    logic [1:0] r_quad, n_quad;
    logic signed [31:0] r_s, n_s;
    logic signed [31:0] r_c, n_c;
    logic signed [65:0] r_prod, n_prod;
    logic signed [33:0] r_f, n_f;
    logic [31:0] r_den, n_den;
    logic [31:0] r_rem, n_rem;
    logic [61:0] r_num, n_num;
    logic [63:0] r_sv, n_sv;
    logic [63:0] r_sr, n_sr;
    logic [63:0] r_sb, n_sb;
    logic [30:0] r_sp, n_sp;
    logic [30:0] r_sm, n_sm;
    logic [31:0] r_nu, n_nu;
    logic r_ovalid, n_ovalid;
    logic [31:0] r_onu, n_onu;
    logic [kes_pkg::ITER_OUT_W-1:0] r_oiter, n_oiter;
    logic r_onc, n_onc;

    // shared multiplier operands
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;

    // cordic step
    logic signed [35:0] w_dx, w_dy;
    logic signed [33:0] w_atan;
    logic w_up;
    logic signed [35:0] w_sx, w_sy;
    logic signed [33:0] w_sz;

    // quadrant map
    logic signed [31:0] w_clx, w_cly;

    // newton terms
    logic [31:0] w_diff;
    logic signed [33:0] w_eterm;
    logic signed [33:0] w_af;
    logic signed [31:0] w_ecos;
    logic [32:0] w_trial;
    logic w_qbit;
    logic [31:0] w_mag;
    logic [31:0] w_enew;
    logic [ITER_W-1:0] w_iter_inc;
    logic w_done_new;
    logic [ITER_W+4:0] w_iter_ext;

    // near-pi test
    logic [31:0] w_dpi;
    logic [31:0] w_adpi;

    // sqrt step
    logic [63:0] w_ssum;
    logic w_sge;
    logic [63:0] w_srn;

    // vectoring set-up
    logic signed [35:0] w_y0;

    logic w_cfg_wr;
    logic w_in_acc;

    assign w_in_acc = i_req.valid && i_req.ready;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // register read port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == kes_pkg::REG_TOL) ? {16'b0, r_tol} : {16'b0, r_ecc};

    // handshake and output payload
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.true_anomaly = r_onu;
    assign o_rsp.iterations_used = r_oiter;
    assign o_rsp.not_converged = r_onc;

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MSIN: begin
                w_ma = {17'b0, r_ecc};
                w_mb = {r_s[31], r_s};
            end
            S_MTERM: begin
                w_ma = {r_prod[47], r_prod[47:16]};
                w_mb = {5'b0, kes_pkg::INV_TWO_PI};
            end
            S_MCOS: begin
                w_ma = {17'b0, r_ecc};
                w_mb = {r_c[31], r_c};
            end
            S_MX: begin
                w_ma = {2'b0, r_sm};
                w_mb = {r_c[31], r_c};
            end
            S_MY: begin
                w_ma = {2'b0, r_sp};
                w_mb = {r_s[31], r_s};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // cordic micro-rotation, rotating or vectoring
    assign w_dx = r_cy >>> r_cnt[4:0];
    assign w_dy = r_cx >>> r_cnt[4:0];
    assign w_atan = {2'b0, kes_pkg::atan_at(r_cnt[4:0])};
    assign w_up = (r_state == S_ROT) ? !r_cz[33] : r_cy[35];
    assign w_sx = w_up ? (r_cx - w_dx) : (r_cx + w_dx);
    assign w_sy = w_up ? (r_cy + w_dy) : (r_cy - w_dy);
    assign w_sz = w_up ? (r_cz - w_atan) : (r_cz + w_atan);

    // clamp to unit
    assign w_clx = (r_cx > 36'sd1073741824) ? 32'sd1073741824 :
                   (r_cx < -36'sd1073741824) ? -32'sd1073741824 : r_cx[31:0];
    assign w_cly = (r_cy > 36'sd1073741824) ? 32'sd1073741824 :
                   (r_cy < -36'sd1073741824) ? -32'sd1073741824 : r_cy[31:0];

    // residual and divider step
    assign w_diff = r_e - r_m;
    assign w_eterm = r_prod[61:28];
    assign w_ecos = r_prod[47:16];
    assign w_af = r_f[33] ? -r_f : r_f;
    assign w_trial = {r_rem, r_num[61]};
    assign w_qbit = (w_trial >= {1'b0, r_den});
    assign w_mag = (r_num > 62'h8000_0000) ? kes_pkg::HALF_TURN : r_num[31:0];
    assign w_enew = r_f[33] ? (r_e + w_mag) : (r_e - w_mag);
    assign w_iter_inc = r_iter + 1'b1;
    assign w_done_new = (w_mag < {16'b0, r_tol});
    assign w_iter_ext = {5'b0, r_iter};

    // distance to pi
    assign w_dpi = r_e ^ kes_pkg::HALF_TURN;
    assign w_adpi = w_dpi[31] ? (32'd0 - w_dpi) : w_dpi;

    // square root digit step
    assign w_ssum = r_sr + r_sb;
    assign w_sge = (r_sv >= w_ssum);
    assign w_srn = w_sge ? ((r_sr >> 1) + r_sb) : (r_sr >> 1);

    assign w_y0 = r_prod[65:30];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ecc = r_ecc;
        n_tol = r_tol;
        n_m = r_m;
        n_e = r_e;
        n_iter = r_iter;
        n_done = r_done;
        n_final = r_final;
        n_cnt = r_cnt;
        n_cx = r_cx;
        n_cy = r_cy;
        n_cz = r_cz;
        n_quad = r_quad;
        n_s = r_s;
        n_c = r_c;
        n_prod = r_prod;
        n_f = r_f;
        n_den = r_den;
        n_rem = r_rem;
        n_num = r_num;
        n_sv = r_sv;
        n_sr = r_sr;
        n_sb = r_sb;
        n_sp = r_sp;
        n_sm = r_sm;
        n_nu = r_nu;
        n_ovalid = r_ovalid;
        n_onu = r_onu;
        n_oiter = r_oiter;
        n_onc = r_onc;

        // configuration write
        if (w_cfg_wr) begin
            if (paddr[2] == kes_pkg::REG_TOL) begin
                n_tol = pwdata[15:0];
            end else begin
                n_ecc = pwdata[15:0];
            end
        end

        // output transaction taken
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_m = i_req.mean_anomaly;
                    n_e = i_req.mean_anomaly;
                    n_iter = '0;
                    n_final = 1'b0;
                    n_quad = i_req.mean_anomaly[31:30];
                    n_cx = {4'b0, kes_pkg::CORDIC_GAIN};
                    n_cy = '0;
                    n_cz = {4'b0, i_req.mean_anomaly[29:0]};
                    n_cnt = '0;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                n_cx = w_sx;
                n_cy = w_sy;
                n_cz = w_sz;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd30) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                case (r_quad)
                    2'd0: begin
                        n_c = w_clx;
                        n_s = w_cly;
                    end
                    2'd1: begin
                        n_c = -w_cly;
                        n_s = w_clx;
                    end
                    2'd2: begin
                        n_c = -w_clx;
                        n_s = -w_cly;
                    end
                    default: begin
                        n_c = w_cly;
                        n_s = -w_clx;
                    end
                endcase
                if (r_final) begin
                    n_sv = {3'b0, (17'd65536 + {1'b0, r_ecc}), 44'b0};
                    n_sr = '0;
                    n_sb = 64'h4000_0000_0000_0000;
                    n_cnt = '0;
                    n_state = S_SQ1;
                end else begin
                    n_state = S_MSIN;
                end
            end
            S_MSIN: begin
                n_prod = w_prod;
                n_state = S_MTERM;
            end
            S_MTERM: begin
                n_prod = w_prod;
                n_state = S_MCOS;
            end
            S_MCOS: begin
                n_f = $signed({{2{w_diff[31]}}, w_diff}) - w_eterm;
                n_prod = w_prod;
                n_state = S_DEN;
            end
            S_DEN: begin
                n_den = 32'h4000_0000 - w_ecos;
                n_num = {w_af[31:0], 30'b0};
                n_rem = '0;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_qbit ? 32'(w_trial - {1'b0, r_den}) : w_trial[31:0];
                n_num = {r_num[60:0], w_qbit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd61) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_e = w_enew;
                n_iter = w_iter_inc;
                n_done = w_done_new;
                if ((w_iter_inc < ITER_W'(MAX_ITER)) && !w_done_new) begin
                    n_quad = w_enew[31:30];
                    n_cx = {4'b0, kes_pkg::CORDIC_GAIN};
                    n_cy = '0;
                    n_cz = {4'b0, w_enew[29:0]};
                    n_cnt = '0;
                    n_state = S_ROT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (w_adpi < {16'b0, r_tol}) begin
                    n_nu = kes_pkg::HALF_TURN;
                    n_state = S_OUT;
                end else begin
                    // half angle for the tangent formula
                    n_final = 1'b1;
                    n_quad = r_e[31:30] >> 1;
                    n_cx = {4'b0, kes_pkg::CORDIC_GAIN};
                    n_cy = '0;
                    n_cz = {4'b0, r_e[30:1]};
                    n_cnt = '0;
                    n_state = S_ROT;
                end
            end
            S_SQ1: begin
                n_sv = w_sge ? (r_sv - w_ssum) : r_sv;
                n_sr = w_srn;
                n_sb = r_sb >> 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd31) begin
                    n_sp = w_srn[30:0];
                    n_sv = {3'b0, (17'd65536 - {1'b0, r_ecc}), 44'b0};
                    n_sr = '0;
                    n_sb = 64'h4000_0000_0000_0000;
                    n_cnt = '0;
                    n_state = S_SQ2;
                end
            end
            S_SQ2: begin
                n_sv = w_sge ? (r_sv - w_ssum) : r_sv;
                n_sr = w_srn;
                n_sb = r_sb >> 2;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd31) begin
                    n_sm = w_srn[30:0];
                    n_state = S_MX;
                end
            end
            S_MX: begin
                n_prod = w_prod;
                n_state = S_MY;
            end
            S_MY: begin
                n_cx = r_prod[65:30];
                n_prod = w_prod;
                n_state = S_VLD;
            end
            S_VLD: begin
                // fold the left half-plane by a quarter turn
                if (r_cx[35]) begin
                    if (!w_y0[35]) begin
                        n_cz = 34'sd1073741824;
                        n_cx = w_y0;
                        n_cy = -r_cx;
                    end else begin
                        n_cz = -34'sd1073741824;
                        n_cx = -w_y0;
                        n_cy = r_cx;
                    end
                end else begin
                    n_cz = '0;
                    n_cy = w_y0;
                end
                n_cnt = '0;
                n_state = S_VEC;
            end
            S_VEC: begin
                n_cx = w_sx;
                n_cy = w_sy;
                n_cz = w_sz;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 6'd30) begin
                    n_nu = {w_sz[30:0], 1'b0};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_onu = r_nu;
                    n_oiter = w_iter_ext[4:0];
                    n_onc = !r_done;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ecc <= '0;
            r_tol <= 16'd16;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ecc <= n_ecc;
            r_tol <= n_tol;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_m <= n_m;
        r_e <= n_e;
        r_iter <= n_iter;
        r_done <= n_done;
        r_final <= n_final;
        r_cnt <= n_cnt;
        r_cx <= n_cx;
        r_cy <= n_cy;
        r_cz <= n_cz;
        r_quad <= n_quad;
        r_s <= n_s;
        r_c <= n_c;
        r_prod <= n_prod;
        r_f <= n_f;
        r_den <= n_den;
        r_rem <= n_rem;
        r_num <= n_num;
        r_sv <= n_sv;
        r_sr <= n_sr;
        r_sb <= n_sb;
        r_sp <= n_sp;
        r_sm <= n_sm;
        r_nu <= n_nu;
        r_onu <= n_onu;
        r_oiter <= n_oiter;
        r_onc <= n_onc;
    end

    // checks
    `KES_CHECK_NEXT(a_accept_starts_rot, w_in_acc, (r_state == S_ROT) && (r_cnt == 6'd0))
    `KES_CHECK(a_div_den_nonzero, r_state == S_DIV, r_den != 32'd0)
    `KES_CHECK(a_unconverged_at_limit, (r_state == S_CHK) && !r_done, r_iter == ITER_W'(MAX_ITER))

endmodule

// File: tb/sv/kepler_equation_solver_tb.sv
`timescale 1ns / 100ps

module kepler_equation_solver_tb;

    localparam int MAX_NEWTON = 16;
    localparam longint Q30 = 64'sd1 << 30;
    localparam longint TURN_MASK = 64'hFFFF_FFFF;
    localparam longint HALF = 64'sd1 << 31;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE_CYCLES = 2000;

    typedef struct packed {
        logic [31:0] nu;
        logic [4:0]  iters;
        logic        nc;
    } anomaly_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kes_in_if req_if ();
    kes_out_if rsp_if ();

    kepler_equation_solver #(.MAX_ITER(MAX_NEWTON)) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if.sink),
        .o_rsp(rsp_if.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor copy of the registers
    longint ecc_q16 = 0;
    longint tol_units = 16;
    anomaly_t expected_anomalies[$];
    int failures = 0;
    int cycle_count = 0;
    bit quiet_mode = 1'b0;

    initial begin
        req_if.valid = 1'b0;
        req_if.mean_anomaly = '0;
        rsp_if.ready = 1'b0;
    end

    // clock
    always #5 i_clk = ~i_clk;

    // floor shift of a signed value
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_q30(input longint v);
        if (v > Q30) return Q30;
        if (v < -Q30) return -Q30;
        return v;
    endfunction

    function automatic longint atan_step(input int i);
        return longint'(kes_pkg::atan_at(5'(i)));
    endfunction

    // rotation cordic, sine and cosine of a binary angle in q1.30
    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        logic [31:0] a;
        longint x, y, z, dx, dy;
        a = ang[31:0];
        x = 64'sd652032874;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < 31; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        x = clamp_q30(x);
        y = clamp_q30(y);
        case (a[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // vectoring cordic, angle of (x, y)
    function automatic logic [31:0] cordic_atan2(input longint x, input longint y);
        longint z, t, dx, dy;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                z = Q30; x = y; y = -t;
            end else begin
                z = -Q30; x = -y; y = t;
            end
        end
        for (int i = 0; i < 31; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z[31:0];
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // floor(a * 2^30 / b), saturated at half a turn
    function automatic longint step_size(input longint unsigned a, input longint unsigned b);
        longint unsigned q, r;
        q = a / b;
        r = a % b;
        for (int i = 0; i < 30; i++) begin
            if (q > HALF) return HALF;
            q <<= 1;
            r <<= 1;
            if (r >= b) begin
                q++;
                r -= b;
            end
        end
        return (q > HALF) ? HALF : longint'(q);
    endfunction

    function automatic longint wrap_half(input longint d);
        d &= TURN_MASK;
        return (d >= HALF) ? d - (64'sd1 << 32) : d;
    endfunction

    // newton solve of kepler's equation, then the true anomaly
    task automatic predict_true_anomaly(input logic [31:0] mean, output anomaly_t res);
        longint m, ea, s, c, esin, eterm, f, den, mag, d, sp, sm;
        int iters;
        bit done;
        logic [31:0] h;
        m = longint'(mean);
        ea = m;
        iters = 0;
        done = 1'b0;
        while (iters < MAX_NEWTON && !done) begin
            cordic_sincos(ea, s, c);
            esin = fshr(ecc_q16 * s, 16);
            eterm = fshr(esin * 64'sd170891319, 28);
            f = wrap_half(ea - m) - eterm;
            den = Q30 - fshr(ecc_q16 * c, 16);
            mag = step_size((f < 0) ? -f : f, den);
            ea = ((f < 0) ? ea + mag : ea - mag) & TURN_MASK;
            iters++;
            done = (mag < tol_units);
        end
        d = wrap_half(ea - HALF);
        if (d < 0) d = -d;
        if (d < tol_units) begin
            res.nu = 32'h8000_0000;
        end else begin
            cordic_sincos(ea >> 1, s, c);
            sp = int_sqrt(longint'(65536 + ecc_q16) << 44);
            sm = int_sqrt(longint'(65536 - ecc_q16) << 44);
            h = cordic_atan2(fshr(sm * c, 30), fshr(sp * s, 30));
            res.nu = {h[30:0], 1'b0};
        end
        res.iters = 5'(iters);
        res.nc = ~done;
    endtask

    function automatic bit stall_now();
        return !quiet_mode && ($urandom_range(99) < 6);
    endfunction

    // send one mean anomaly transaction
    task automatic send_mean_anomaly(input logic [31:0] mean);
        anomaly_t exp_res;
        while (stall_now()) @(negedge i_clk);
        predict_true_anomaly(mean, exp_res);
        req_if.valid = 1'b1;
        req_if.mean_anomaly = mean;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        expected_anomalies.push_back(exp_res);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_anomalies.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write, setup then access
    task automatic write_register(input logic idx, input logic [15:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 3'(idx) << 2;
        pwdata = {16'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == kes_pkg::REG_ECC) ecc_q16 = value;
        else tol_units = value;
    endtask

    task automatic configure(input logic [15:0] ecc, input logic [15:0] tol);
        wait_drained();
        write_register(kes_pkg::REG_ECC, ecc);
        write_register(kes_pkg::REG_TOL, tol);
    endtask

    // response side: random stalls, check each transaction
    always @(negedge i_clk) begin
        if (i_rst_n) rsp_if.ready <= !stall_now();
    end

    always @(posedge i_clk) begin
        anomaly_t exp_res;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_anomalies.size() == 0) begin
                $error("unexpected transaction, true_anomaly %h", rsp_if.true_anomaly);
                failures++;
            end else begin
                exp_res = expected_anomalies.pop_front();
                if (rsp_if.true_anomaly !== exp_res.nu) begin
                    $error("true_anomaly expected %h actual %h", exp_res.nu,
                           rsp_if.true_anomaly);
                    failures++;
                end
                if (rsp_if.iterations_used !== exp_res.iters) begin
                    $error("iterations_used expected %0d actual %0d", exp_res.iters,
                           rsp_if.iterations_used);
                    failures++;
                end
                if (rsp_if.not_converged !== exp_res.nc) begin
                    $error("not_converged expected %0d actual %0d", exp_res.nc,
                           rsp_if.not_converged);
                    failures++;
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // corners of the mean anomaly at the reset settings
    task automatic test_reset_defaults();
        send_mean_anomaly(32'h0000_0000);
        send_mean_anomaly(32'hFFFF_FFFF);
        send_mean_anomaly(32'h8000_0000);
        send_mean_anomaly(32'h4000_0000);
    endtask

    // eccentricity extremes and near-pi cases
    task automatic test_eccentricity_extremes();
        configure(16'hFFFF, 16'd16);
        send_mean_anomaly(32'h0000_0001);
        send_mean_anomaly(32'h8000_0000);
        send_mean_anomaly(32'h7FFF_FFF0);
        send_mean_anomaly(32'hC000_0000);
        send_mean_anomaly(32'h0100_0000);
        configure(16'h8000, 16'd1);
        send_mean_anomaly(32'h8000_0000);
        send_mean_anomaly(32'h5555_5555);
        send_mean_anomaly(32'hAAAA_AAAA);
    endtask

    // a huge tolerance, which also hits the pi case; then a tight one at high eccentricity
    task automatic test_tolerance_extremes();
        configure(16'h4000, 16'hFFFF);
        send_mean_anomaly(32'h8000_1000);
        send_mean_anomaly(32'h2000_0000);
        send_mean_anomaly(32'hE000_0000);
        configure(16'hF000, 16'd1);
        send_mean_anomaly(32'h0000_8000);
        send_mean_anomaly(32'hFFFF_0000);
    endtask

    // random anomalies under a sweep of settings, with idling
    task automatic test_random_anomalies();
        logic [31:0] mean;
        for (int ph = 0; ph < 10; ph++) begin
            configure(16'($urandom), 16'($urandom_range(65535, 1)));
            quiet_mode = (ph == 4);
            for (int k = 0; k < 50; k++) begin
                case ($urandom_range(3))
                    0: mean = 32'h8000_0000 + 32'($urandom_range(256)) - 32'd128;
                    1: mean = $urandom_range(1) ? 32'($urandom_range(255)) :
                              ~32'($urandom_range(255));
                    default: mean = $urandom;
                endcase
                send_mean_anomaly(mean);
                // hold off until all results are back
                if (k == 25) while (expected_anomalies.size() != 0) @(negedge i_clk);
            end
            quiet_mode = 1'b0;
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_eccentricity_extremes();
        test_tolerance_extremes();
        test_random_anomalies();
        wait_drained();
        if (failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/kes_pkg.sv
rtl/core/kes_if.sv
rtl/core/kepler_equation_solver.sv
tb/sv/kepler_equation_solver_tb.sv
